/* rtl/spc_pkg.sv */
// Shared types, register indexes and reset values for the servo position and sweep control.
package spc_pkg;

   // Configuration register indexes
   localparam int unsigned CsrIndexWidth = 3;
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PULSE_MIN         = 3'd0,
      CSR_PULSE_MAX         = 3'd1,
      CSR_POSITION_OFFSET   = 3'd2,
      CSR_POSITION_DEADBAND = 3'd3,
      CSR_RATE_DEADBAND     = 3'd4,
      CSR_SWEEP_THRESHOLD   = 3'd5,
      CSR_RATE_BASE         = 3'd6
   } csr_index_type;

   localparam int unsigned CsrDataWidth = 8;

   // Register reset values
   localparam logic [7:0] PulseMinReset         = 8'd75;
   localparam logic [7:0] PulseMaxReset         = 8'd205;
   localparam logic [6:0] PositionOffsetReset   = 7'd75;
   localparam logic [7:0] PositionDeadbandReset = 8'd3;
   localparam logic [6:0] RateDeadbandReset     = 7'd5;
   localparam logic [7:0] SweepThresholdReset   = 8'd10;
   localparam logic [6:0] RateBaseReset         = 7'd70;

   // State reset values
   localparam logic [7:0] WidthCountReset  = 8'd160;
   localparam logic [6:0] PeriodValueReset = 7'd9;

   typedef struct packed {
      logic [7:0] pulse_min;
      logic [7:0] pulse_max;
      logic [6:0] position_offset;
      logic [7:0] position_deadband;
      logic [6:0] rate_deadband;
      logic [7:0] sweep_threshold;
      logic [6:0] rate_base;
   } cfg_type;

   typedef struct packed {
      logic [7:0] sample;
      logic       position_mode;
      logic       sweep_step;
   } item_type;

   typedef struct packed {
      logic [7:0] pulse_width;
      logic [6:0] sweep_period;
      logic       period_changed;
   } result_type;

endpackage

/* rtl/spc_req_if.sv */
// Input channel carrying one control sample beat.
interface spc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       position_mode;
   logic       sweep_step;

   modport source (output valid, output sample, output position_mode, output sweep_step,
                   input ready);
   modport sink (input valid, input sample, input position_mode, input sweep_step,
                 output ready);
endinterface

/* rtl/spc_rsp_if.sv */
// Result channel carrying one pulse width and sweep period beat.
interface spc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pulse_width;
   logic [6:0] sweep_period;
   logic       period_changed;

   modport source (output valid, output pulse_width, output sweep_period,
                   output period_changed, input ready);
   modport sink (input valid, input pulse_width, input sweep_period,
                 input period_changed, output ready);
endinterface

/* rtl/spc_csr.sv */
// Configuration register file with a plain write port.
module spc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [spc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [spc_pkg::CsrDataWidth-1:0]    csr_write_data,
   output spc_pkg::cfg_type                    cfg
);
   import spc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write and update one register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PULSE_MIN:         cfg_in.pulse_min         = csr_write_data;
            CSR_PULSE_MAX:         cfg_in.pulse_max         = csr_write_data;
            CSR_POSITION_OFFSET:   cfg_in.position_offset   = csr_write_data[6:0];
            CSR_POSITION_DEADBAND: cfg_in.position_deadband = csr_write_data;
            CSR_RATE_DEADBAND:     cfg_in.rate_deadband     = csr_write_data[6:0];
            CSR_SWEEP_THRESHOLD:   cfg_in.sweep_threshold   = csr_write_data;
            CSR_RATE_BASE:         cfg_in.rate_base         = csr_write_data[6:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min         <= PulseMinReset;
         cfg_ff.pulse_max         <= PulseMaxReset;
         cfg_ff.position_offset   <= PositionOffsetReset;
         cfg_ff.position_deadband <= PositionDeadbandReset;
         cfg_ff.rate_deadband     <= RateDeadbandReset;
         cfg_ff.sweep_threshold   <= SweepThresholdReset;
         cfg_ff.rate_base         <= RateBaseReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/spc_core.sv */
// Filter, position and sweep state with its single-pass update logic.
module spc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  spc_pkg::item_type    item,
   input  spc_pkg::cfg_type     cfg,
   output spc_pkg::result_type  result
);
   import spc_pkg::*;

   logic [15:0] acc_ff, acc_in;
   logic        primed_ff, primed_in;
   logic [7:0]  last_position_ff, last_position_in;
   logic [7:0]  width_count_ff, width_count_in;
   logic        sweeping_up_ff, sweeping_up_in;
   logic [6:0]  last_rate_ff, last_rate_in;
   logic [6:0]  period_value_ff, period_value_in;
   logic        step_pending_ff, step_pending_in;
   logic        changed;

   logic [16:0]       acc_sum;
   logic [7:0]        filt;
   logic [7:0]        pos_diff;
   logic [5:0]        quarter;
   logic [6:0]        rate;
   logic [6:0]        rate_diff;
   logic              pending;
   logic signed [9:0] step_val;

   always_comb begin
      acc_in          = acc_ff;
      primed_in       = primed_ff;
      last_position_in = last_position_ff;
      width_count_in  = width_count_ff;
      sweeping_up_in  = sweeping_up_ff;
      last_rate_in    = last_rate_ff;
      period_value_in = period_value_ff;
      changed         = 1'b0;

      // Latch the timer flag
      pending = step_pending_ff | item.sweep_step;
      step_pending_in = pending;

      // Advance the 1/256 average
      acc_sum = {1'b0, acc_ff} - {9'd0, acc_ff[15:8]} + {9'd0, item.sample};
      filt    = acc_sum[15:8];

      pos_diff  = (last_position_ff > filt) ? last_position_ff - filt : filt - last_position_ff;
      quarter   = filt[7:2];
      rate      = (cfg.rate_base > {1'b0, quarter}) ? cfg.rate_base - {1'b0, quarter} : 7'd0;
      rate_diff = (last_rate_ff > rate) ? last_rate_ff - rate : rate - last_rate_ff;

      // Sweep step with reversal at the limits
      step_val = $signed({2'b00, width_count_ff}) + (sweeping_up_ff ? 10'sd1 : -10'sd1);

      if (!primed_ff) begin
         // Seed from the first sample
         acc_in           = {item.sample, 8'd0};
         last_position_in = item.sample;
         width_count_in   = {1'b0, item.sample[7:1]} + {1'b0, cfg.position_offset};
         primed_in        = 1'b1;
      end else begin
         acc_in = acc_sum[15:0];
         if (item.position_mode) begin
            if (pos_diff > cfg.position_deadband) begin
               last_position_in = filt;
               width_count_in   = {1'b0, filt[7:1]} + {1'b0, cfg.position_offset};
            end
         end else if (filt > cfg.sweep_threshold) begin
            if (rate_diff > cfg.rate_deadband) begin
               period_value_in = rate;
               last_rate_in    = rate;
               changed         = 1'b1;
            end
            if (pending) begin
               step_pending_in = 1'b0;
               if (step_val >= $signed({2'b00, cfg.pulse_max})) begin
                  step_val       = step_val - 10'sd1;
                  sweeping_up_in = 1'b0;
               end else if (step_val <= $signed({2'b00, cfg.pulse_min})) begin
                  step_val       = step_val + 10'sd1;
                  sweeping_up_in = 1'b1;
               end
               if (step_val < 10'sd0) begin
                  width_count_in = 8'd0;
               end else if (step_val > 10'sd255) begin
                  width_count_in = 8'd255;
               end else begin
                  width_count_in = step_val[7:0];
               end
            end
         end
      end

      result.pulse_width    = width_count_in;
      result.sweep_period   = period_value_in;
      result.period_changed = changed;
   end

   // Commit state once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff           <= 16'd0;
         primed_ff        <= 1'b0;
         last_position_ff <= 8'd0;
         width_count_ff   <= WidthCountReset;
         sweeping_up_ff   <= 1'b1;
         last_rate_ff     <= 7'd0;
         period_value_ff  <= PeriodValueReset;
         step_pending_ff  <= 1'b0;
      end else if (fire) begin
         acc_ff           <= acc_in;
         primed_ff        <= primed_in;
         last_position_ff <= last_position_in;
         width_count_ff   <= width_count_in;
         sweeping_up_ff   <= sweeping_up_in;
         last_rate_ff     <= last_rate_in;
         period_value_ff  <= period_value_in;
         step_pending_ff  <= step_pending_in;
      end
   end

endmodule

/* rtl/servo_position_and_sweep_control.sv */
// A beat accepted into the input register is loaded into the result register when the
// result stage can take it, and its result is then offered on the response channel.
// Throughput: one beat per cycle unless the result stage stalls; the state loop is combinational.
// A stalled result stage holds the input register full, then drops req ready.
// Reset (synchronous, active high) restores register defaults, clears the filter
// and priming, and empties both pipeline stages.
module servo_position_and_sweep_control (
   input  logic                              clock,
   input  logic                              reset,
   spc_req_if.sink                           req_chan,
   spc_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [spc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [spc_pkg::CsrDataWidth-1:0]  csr_write_data
);
   import spc_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type result_in;
   result_type result_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       fire;

   spc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Result stage can take a new beat when empty or draining
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign fire    = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   // Hold the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         item_ff.sample        <= req_chan.sample;
         item_ff.position_mode <= req_chan.position_mode;
         item_ff.sweep_step    <= req_chan.sweep_step;
      end
   end

   spc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result_in)
   );

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.pulse_width    = result_ff.pulse_width;
   assign rsp_chan.sweep_period   = result_ff.sweep_period;
   assign rsp_chan.period_changed = result_ff.period_changed;

endmodule
